/* hdl/pnmhp_pkg.sv */
// Package for the binary PGM/PPM header parser.
// Holds parse phase and event codes plus the character constants; no dependencies.
package pnmhp_pkg;

  typedef enum logic [1:0] {
    PH_SKIP    = 2'd0,
    PH_TOKEN   = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_DONE    = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    EV_HEADER      = 2'd0,
    EV_PIXEL       = 2'd1,
    EV_UNSUPPORTED = 2'd2,
    EV_TRUNCATED   = 2'd3
  } event_e;

  localparam logic [7:0]  CharHash    = 8'h23;
  localparam logic [7:0]  CharNewline = 8'h0A;
  localparam logic [7:0]  CharSpace   = 8'h20;
  localparam logic [7:0]  CharTab     = 8'h09;
  localparam logic [7:0]  CharCr      = 8'h0D;
  localparam logic [31:0] CharZero    = 32'h0000_0030;
  localparam logic [15:0] MagicP5     = 16'h5035;
  localparam logic [15:0] MagicP6     = 16'h5036;
  localparam logic [31:0] MaxvalByte  = 32'd255;

  localparam logic [1:0]  TokMagic  = 2'd0;
  localparam logic [1:0]  TokWidth  = 2'd1;
  localparam logic [1:0]  TokHeight = 2'd2;
  localparam logic [1:0]  TokMaxval = 2'd3;

  function automatic logic is_ws(input logic [7:0] c);
    is_ws = (c == CharSpace) || ((c >= CharTab) && (c <= CharCr));
  endfunction

endpackage

/* hdl/pnm_header_parser.sv */
// Each result is registered: it appears in the cycle after the item that causes it is accepted.
// Throughput: one item per cycle; the input is taken whenever the result register is
// empty or being read in the same cycle.
// The pixel count is formed by one registered 32x32 multiply that runs every cycle.
// Reset (rst_ni low, asynchronous) returns the parser to token search with no result held.
// Depends on pnmhp_pkg.
module pnm_header_parser
  import pnmhp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        kind_i,
  input  logic [7:0]  byte_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  event_res_o,
  output logic [7:0]  pixel_byte_o,
  output logic        last_byte_o,
  output logic [31:0] image_width_o,
  output logic [31:0] image_height_o,
  output logic        is_color_o
);

  phase_e      phase_q, phase_d;
  logic [1:0]  tok_q, tok_d;
  logic        cmt_q, cmt_d;
  logic [15:0] magic_q, magic_d;
  logic [1:0]  mlen_q, mlen_d;
  logic [31:0] acc_q, acc_d;
  logic [31:0] width_q, width_d;
  logic [31:0] height_q, height_d;
  logic [33:0] left_q, left_d;
  logic [31:0] pix_q;

  logic        ov_q;
  logic [1:0]  ev_q;
  logic [7:0]  pb_q;
  logic        lb_q;
  logic [31:0] ow_q, oh_q;
  logic        oc_q;

  logic        accept;
  logic        res_valid;
  logic [1:0]  res_ev;
  logic [7:0]  res_pb;
  logic        res_lb;
  logic [31:0] res_w, res_h;
  logic        res_c;

  logic [31:0] acc_base;
  logic [31:0] acc_step;
  logic        p5, p6;

  assign in_ready_o = !ov_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // Accumulator update: acc*10 + (byte - '0'), with acc read as zero in token search, wrapping at 32 bits.
  assign acc_base = (phase_q == PH_SKIP) ? 32'd0 : acc_q;
  assign acc_step = (acc_base << 3) + (acc_base << 1) + {24'd0, byte_value_i} - CharZero;

  assign p5 = (magic_q == MagicP5);
  assign p6 = (magic_q == MagicP6);

  always_comb begin
    phase_d   = phase_q;
    tok_d     = tok_q;
    cmt_d     = cmt_q;
    magic_d   = magic_q;
    mlen_d    = mlen_q;
    acc_d     = acc_q;
    width_d   = width_q;
    height_d  = height_q;
    left_d    = left_q;
    res_valid = 1'b0;
    res_ev    = EV_HEADER;
    res_pb    = 8'd0;
    res_lb    = 1'b0;
    res_w     = 32'd0;
    res_h     = 32'd0;
    res_c     = 1'b0;

    if (kind_i) begin
      if (phase_q != PH_DONE) begin
        res_valid = 1'b1;
        res_ev    = EV_TRUNCATED;
      end
      phase_d  = PH_SKIP;
      tok_d    = TokMagic;
      cmt_d    = 1'b0;
      magic_d  = 16'd0;
      mlen_d   = 2'd0;
      acc_d    = 32'd0;
      width_d  = 32'd0;
      height_d = 32'd0;
      left_d   = 34'd0;
    end else begin
      case (phase_q)
        PH_SKIP, PH_TOKEN: begin
          if (phase_q == PH_SKIP && cmt_q) begin
            if (byte_value_i == CharNewline) begin
              cmt_d = 1'b0;
            end
          end else if (phase_q == PH_SKIP && byte_value_i == CharHash) begin
            cmt_d = 1'b1;
          end else if (is_ws(byte_value_i)) begin
            // Whitespace ends a token; in token search it is simply skipped.
            if (phase_q == PH_TOKEN) begin
              phase_d = PH_SKIP;
              tok_d   = tok_q + 2'd1;
              case (tok_q)
                TokWidth:  width_d  = acc_q;
                TokHeight: height_d = acc_q;
                TokMaxval: begin
                  res_valid = 1'b1;
                  phase_d   = PH_DONE;
                  if (mlen_q == 2'd2 && (p5 || p6) && acc_q == MaxvalByte) begin
                    res_ev = EV_HEADER;
                    res_w  = width_q;
                    res_h  = height_q;
                    res_c  = p6;
                    left_d = p6 ? ({2'd0, pix_q} + {1'b0, pix_q, 1'b0}) : {2'd0, pix_q};
                    if (pix_q != 32'd0) begin
                      phase_d = PH_PAYLOAD;
                    end
                  end else begin
                    res_ev = EV_UNSUPPORTED;
                  end
                end
                default: ;
              endcase
            end
          end else begin
            phase_d = PH_TOKEN;
            if (tok_q == TokMagic) begin
              if (mlen_q < 2'd2) begin
                magic_d = {magic_q[7:0], byte_value_i};
              end
              if (mlen_q != 2'd3) begin
                mlen_d = mlen_q + 2'd1;
              end
            end else begin
              acc_d = acc_step;
            end
          end
        end
        PH_PAYLOAD: begin
          res_valid = 1'b1;
          res_ev    = EV_PIXEL;
          res_pb    = byte_value_i;
          res_lb    = (left_q == 34'd1);
          left_d    = left_q - 34'd1;
          if (left_q == 34'd1) begin
            phase_d = PH_DONE;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_SKIP;
      tok_q    <= TokMagic;
      cmt_q    <= 1'b0;
      magic_q  <= 16'd0;
      mlen_q   <= 2'd0;
      acc_q    <= 32'd0;
      width_q  <= 32'd0;
      height_q <= 32'd0;
      left_q   <= 34'd0;
      ov_q     <= 1'b0;
    end else begin
      if (accept) begin
        phase_q  <= phase_d;
        tok_q    <= tok_d;
        cmt_q    <= cmt_d;
        magic_q  <= magic_d;
        mlen_q   <= mlen_d;
        acc_q    <= acc_d;
        width_q  <= width_d;
        height_q <= height_d;
        left_q   <= left_d;
      end
      if (accept && res_valid) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  // The registered pixel count settles before maxval can end, since
  // maxval needs a digit and a whitespace item after the height is stored.
  always_ff @(posedge clk_i) begin
    pix_q <= width_q * height_q;
    if (accept && res_valid) begin
      ev_q <= res_ev;
      pb_q <= res_pb;
      lb_q <= res_lb;
      ow_q <= res_w;
      oh_q <= res_h;
      oc_q <= res_c;
    end
  end

  assign out_valid_o    = ov_q;
  assign event_res_o    = ev_q;
  assign pixel_byte_o   = pb_q;
  assign last_byte_o    = lb_q;
  assign image_width_o  = ow_q;
  assign image_height_o = oh_q;
  assign is_color_o     = oc_q;

endmodule

/* hdl/pnmhp_checker.sv */
// Port-level checker for pnm_header_parser, attached by the bind below.
// Depends on pnmhp_pkg for the event codes.
module pnmhp_checker
  import pnmhp_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  event_res_o,
  input logic [7:0]  pixel_byte_o,
  input logic        last_byte_o,
  input logic [31:0] image_width_o,
  input logic [31:0] image_height_o,
  input logic        is_color_o
);

  // A result that waits keeps its event, pixel byte and last mark.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(event_res_o)
      && $stable(pixel_byte_o) && $stable(last_byte_o))
    else $error("pending result changed");

  // An empty result register always takes a new item.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty result register");

  // Only payload items carry a byte or a last mark.
  a_pixel_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_res_o != EV_PIXEL |-> pixel_byte_o == 8'd0 && !last_byte_o)
    else $error("pixel fields set on a non-payload item");

  // Only the header item carries dimensions and color.
  a_header_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_res_o != EV_HEADER
      |-> image_width_o == 32'd0 && image_height_o == 32'd0 && !is_color_o)
    else $error("header fields set on a non-header item");

endmodule

bind pnm_header_parser pnmhp_checker u_pnmhp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .event_res_o    (event_res_o),
  .pixel_byte_o   (pixel_byte_o),
  .last_byte_o    (last_byte_o),
  .image_width_o  (image_width_o),
  .image_height_o (image_height_o),
  .is_color_o     (is_color_o)
);

/* bench/pnm_header_parser_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for pnm_header_parser: a directed table, then random netpbm frames.
// Results are compared with a behavioral parser kept in this file. Depends on pnmhp_pkg.
module pnm_header_parser_tb
  import pnmhp_pkg::*;
();

  localparam int         ItemTarget  = 1150;
  localparam int         HoldCycles  = 300;
  localparam int         StallLimit  = 2000;
  localparam logic [7:0] CharVertTab = 8'h0B;
  localparam logic [7:0] CharFormFd  = 8'h0C;

  typedef struct packed {
    event_e      ev;
    logic [7:0]  pixel;
    logic        last;
    logic [31:0] width;
    logic [31:0] height;
    logic        color;
  } pnm_result_t;

  typedef struct packed {
    logic        k;
    logic [7:0]  b;
    logic        typed;
    logic        some;
    pnm_result_t res;
  } stim_row_t;

  localparam pnm_result_t NoResult = '{EV_HEADER, 8'h00, 1'b0, 32'd0, 32'd0, 1'b0};

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        kind_i;
  logic [7:0]  byte_value_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [1:0]  event_res_o;
  logic [7:0]  pixel_byte_o;
  logic        last_byte_o;
  logic [31:0] image_width_o;
  logic [31:0] image_height_o;
  logic        is_color_o;

  pnm_header_parser dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .kind_i         (kind_i),
    .byte_value_i   (byte_value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .event_res_o    (event_res_o),
    .pixel_byte_o   (pixel_byte_o),
    .last_byte_o    (last_byte_o),
    .image_width_o  (image_width_o),
    .image_height_o (image_height_o),
    .is_color_o     (is_color_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Parser state mirrored by the testbench.
  phase_e      p_phase;
  logic [1:0]  p_tok;
  logic        p_in_comment;
  logic [15:0] p_magic;
  logic [1:0]  p_magic_len;
  logic [31:0] p_acc;
  logic [31:0] p_width;
  logic [31:0] p_height;
  logic [33:0] p_remain;
  logic        p_color;

  pnm_result_t pending_results [$];
  pnm_result_t expected_head;
  stim_row_t   directed_rows [28];
  logic [7:0]  header_bytes [$];
  int          error_count = 0;
  int          items_sent = 0;
  int          quiet_cycles = 0;
  int          holds_done = 0;
  bit          steady = 1'b0;
  bit          hold_req = 1'b0;

  function automatic void clear_parser();
    p_phase      = PH_SKIP;
    p_tok        = TokMagic;
    p_in_comment = 1'b0;
    p_magic      = '0;
    p_magic_len  = '0;
    p_acc        = '0;
    p_width      = '0;
    p_height     = '0;
    p_remain     = '0;
    p_color      = 1'b0;
  endfunction

  function automatic bit is_space(input logic [7:0] c);
    return (c == CharSpace) || ((c >= CharTab) && (c <= CharCr));
  endfunction

  function automatic void take_token_char(input logic [7:0] c);
    if (p_tok == TokMagic) begin
      if (p_magic_len < 2'd2) p_magic = {p_magic[7:0], c};
      if (p_magic_len < 2'd3) p_magic_len = p_magic_len + 2'd1;
    end else begin
      p_acc = p_acc * 32'd10 + ({24'd0, c} - CharZero);
    end
  endfunction

  // Advances the mirrored parser by one item; returns 1 when the item yields a result.
  function automatic bit parse_byte(input logic k, input logic [7:0] c, output pnm_result_t r);
    logic [1:0]  done_tok;
    logic [31:0] pixels;
    bit          produced;
    r = NoResult;
    produced = 1'b0;
    if (k) begin
      if (p_phase != PH_DONE) begin
        produced = 1'b1;
        r.ev = EV_TRUNCATED;
      end
      clear_parser();
      return produced;
    end
    case (p_phase)
      PH_SKIP: begin
        if (p_in_comment) begin
          if (c == CharNewline) p_in_comment = 1'b0;
        end else if (c == CharHash) begin
          p_in_comment = 1'b1;
        end else if (!is_space(c)) begin
          if (p_tok != TokMagic) p_acc = '0;
          take_token_char(c);
          p_phase = PH_TOKEN;
        end
      end
      PH_TOKEN: begin
        if (!is_space(c)) begin
          take_token_char(c);
        end else begin
          done_tok = p_tok;
          p_phase = PH_SKIP;
          p_tok = p_tok + 2'd1;
          if (done_tok == TokWidth) begin
            p_width = p_acc;
          end else if (done_tok == TokHeight) begin
            p_height = p_acc;
          end else if (done_tok == TokMaxval) begin
            produced = 1'b1;
            p_phase = PH_DONE;
            if (p_magic_len == 2'd2 && (p_magic == MagicP5 || p_magic == MagicP6) &&
                p_acc == MaxvalByte) begin
              pixels = p_width * p_height;
              p_color = (p_magic == MagicP6);
              p_remain = 34'(pixels) * (p_color ? 34'd3 : 34'd1);
              if (p_remain != '0) p_phase = PH_PAYLOAD;
              r.ev = EV_HEADER;
              r.width = p_width;
              r.height = p_height;
              r.color = p_color;
            end else begin
              r.ev = EV_UNSUPPORTED;
            end
          end
        end
      end
      PH_PAYLOAD: begin
        p_remain = p_remain - 34'd1;
        produced = 1'b1;
        r.ev = EV_PIXEL;
        r.pixel = c;
        r.last = (p_remain == '0);
        if (p_remain == '0) p_phase = PH_DONE;
      end
      default: ;
    endcase
    return produced;
  endfunction

  // Offers one item, waits until it is taken, and advances the mirrored parser.
  task automatic offer(input logic k, input logic [7:0] c, output bit some,
                       output pnm_result_t r);
    if (!steady) begin
      while ($urandom_range(99) < 26) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i   <= 1'b1;
    kind_i       <= k;
    byte_value_i <= c;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    items_sent++;
    some = parse_byte(k, c, r);
  endtask

  task automatic send_byte(input logic [7:0] c);
    bit          some;
    pnm_result_t r;
    offer(1'b0, c, some, r);
    if (some) pending_results = {pending_results, r};
  endtask

  task automatic send_eos();
    bit          some;
    pnm_result_t r;
    offer(1'b1, 8'($urandom_range(255)), some, r);
    if (some) pending_results = {pending_results, r};
  endtask

  function automatic logic [7:0] ws_char();
    case ($urandom_range(5))
      0: return CharSpace;
      1: return CharTab;
      2: return CharNewline;
      3: return CharVertTab;
      4: return CharFormFd;
      default: return CharCr;
    endcase
  endfunction

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) header_bytes = {header_bytes, s[i]};
  endfunction

  // Whitespace between tokens, sometimes with a comment line in it.
  function automatic void add_gap();
    logic [7:0] c;
    repeat ($urandom_range(1, 3)) header_bytes = {header_bytes, ws_char()};
    if ($urandom_range(6) == 0) begin
      header_bytes = {header_bytes, CharHash};
      repeat ($urandom_range(0, 5)) begin
        c = 8'($urandom_range(255));
        header_bytes = {header_bytes, ((c == CharNewline) ? CharVertTab : c)};
      end
      header_bytes = {header_bytes, CharNewline};
      if ($urandom_range(1) == 1) header_bytes = {header_bytes, ws_char()};
    end
  endfunction

  // Mostly tiny sizes; sometimes extremes and digit strings that wrap the accumulator.
  function automatic string dim_text();
    int    sel;
    string s;
    sel = $urandom_range(99);
    if (sel < 8) begin
      s = "0";
    end else if (sel < 70) begin
      s = $sformatf("%0d", $urandom_range(1, 5));
    end else if (sel < 80) begin
      case ($urandom_range(3))
        0: s = "4294967295";
        1: s = "65536";
        2: s = "4294967296";
        default: s = "99999999999";
      endcase
    end else if (sel < 90) begin
      s = $sformatf("%0d", $urandom());
    end else begin
      s = "";
      repeat ($urandom_range(10, 12)) s = {s, $sformatf("%0d", $urandom_range(9))};
    end
    if ($urandom_range(9) == 0) s = {"0", s};
    return s;
  endfunction

  task automatic run_frame(input int frame_no);
    int         sel;
    int         flaw;
    int         cut;
    int         n;
    bit         full;
    logic [33:0] due;
    string      magic_txt;
    string      wtxt;
    string      htxt;
    string      mtxt;
    sel = $urandom_range(99);
    if (sel >= 85) begin
      repeat ($urandom_range(0, 20)) send_byte(8'($urandom_range(255)));
      send_eos();
      return;
    end
    magic_txt = ($urandom_range(1) == 1) ? "P6" : "P5";
    wtxt = dim_text();
    htxt = dim_text();
    if ($urandom_range(19) == 0) begin
      // The pixel count wraps to zero here, so the payload is empty.
      wtxt = "65536";
      htxt = "65536";
    end
    mtxt = ($urandom_range(9) == 0) ? "00255" : "255";
    flaw = (sel >= 70) ? $urandom_range(1, 5) : 0;
    case (flaw)
      1: begin
        case ($urandom_range(4))
          0: magic_txt = "P7";
          1: magic_txt = "P55";
          2: magic_txt = "p5";
          3: magic_txt = "P";
          default: magic_txt = "P6P5";
        endcase
      end
      2: mtxt = $sformatf("%0d", $urandom_range(0, 1000));
      4: begin
        // A hash inside a token belongs to the token.
        if ($urandom_range(1) == 1) mtxt = "255#";
        else magic_txt = {magic_txt, "#"};
      end
      default: ;
    endcase
    header_bytes.delete();
    if ($urandom_range(3) == 0) add_gap();
    add_text(magic_txt);
    add_gap();
    add_text(wtxt);
    add_gap();
    add_text(htxt);
    add_gap();
    add_text(mtxt);
    header_bytes = {header_bytes, ws_char()};
    if (flaw == 3) begin
      header_bytes.insert($urandom_range(0, header_bytes.size() - 1), 8'($urandom_range(255)));
    end
    cut = (flaw == 5) ? $urandom_range(0, header_bytes.size() - 1) : header_bytes.size();
    for (int i = 0; i < cut; i++) send_byte(header_bytes[i]);
    if (cut < header_bytes.size()) begin
      send_eos();
      return;
    end
    if (p_phase == PH_PAYLOAD) begin
      due = p_remain;
      full = (due <= 34'd200) && ($urandom_range(4) != 0);
      if (full) n = int'(due);
      else if (due <= 34'd200) n = $urandom_range(0, int'(due) - 1);
      else n = $urandom_range(0, 6);
      if (n >= 6 && holds_done < 2 && frame_no >= ((holds_done == 0) ? 3 : 20)) begin
        hold_req = 1'b1;
        holds_done++;
      end
      repeat (n) send_byte(8'($urandom_range(255)));
      if (!full) begin
        send_eos();
        return;
      end
    end
    repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(255)));
    send_eos();
  endtask

  // Receiver: random stalls, a quiet stretch, and long hold-offs on request.
  initial begin
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else begin
        out_ready_i <= steady || ($urandom_range(99) >= 26);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("result with no item waiting: event_res %0d", event_res_o);
        error_count++;
      end else begin
        expected_head = pending_results.pop_front();
        if (event_res_o !== expected_head.ev) begin
          $error("event_res: expected %0d, got %0d", expected_head.ev, event_res_o);
          error_count++;
        end
        if (pixel_byte_o !== expected_head.pixel) begin
          $error("pixel_byte: expected %0d, got %0d", expected_head.pixel, pixel_byte_o);
          error_count++;
        end
        if (last_byte_o !== expected_head.last) begin
          $error("last_byte: expected %0d, got %0d", expected_head.last, last_byte_o);
          error_count++;
        end
        if (image_width_o !== expected_head.width) begin
          $error("image_width: expected %0d, got %0d", expected_head.width, image_width_o);
          error_count++;
        end
        if (image_height_o !== expected_head.height) begin
          $error("image_height: expected %0d, got %0d", expected_head.height, image_height_o);
          error_count++;
        end
        if (is_color_o !== expected_head.color) begin
          $error("is_color: expected %0d, got %0d", expected_head.color, is_color_o);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("FAIL pnm_header_parser");
        $finish;
      end
    end
  end

  initial begin
    bit          some;
    pnm_result_t r;
    int          frame_no;
    rst_ni       <= 1'b0;
    in_valid_i   <= 1'b0;
    kind_i       <= 1'b0;
    byte_value_i <= 8'h00;
    clear_parser();
    directed_rows = '{
      '{1'b1, 8'hFF,       1'b1, 1'b1, '{EV_TRUNCATED, 8'h00, 1'b0, 32'd0, 32'd0, 1'b0}},
      '{1'b0, "P",         1'b0, 1'b0, NoResult},
      '{1'b0, "6",         1'b0, 1'b0, NoResult},
      '{1'b0, CharSpace,   1'b0, 1'b0, NoResult},
      '{1'b0, CharHash,    1'b0, 1'b0, NoResult},
      '{1'b0, CharNewline, 1'b0, 1'b0, NoResult},
      '{1'b0, "1",         1'b0, 1'b0, NoResult},
      '{1'b0, CharTab,     1'b0, 1'b0, NoResult},
      '{1'b0, "1",         1'b0, 1'b0, NoResult},
      '{1'b0, CharCr,      1'b0, 1'b0, NoResult},
      '{1'b0, "2",         1'b0, 1'b0, NoResult},
      '{1'b0, "5",         1'b0, 1'b0, NoResult},
      '{1'b0, "5",         1'b0, 1'b0, NoResult},
      '{1'b0, CharSpace,   1'b1, 1'b1, '{EV_HEADER, 8'h00, 1'b0, 32'd1, 32'd1, 1'b1}},
      '{1'b0, 8'h00,       1'b1, 1'b1, '{EV_PIXEL, 8'h00, 1'b0, 32'd0, 32'd0, 1'b0}},
      '{1'b0, 8'hFF,       1'b1, 1'b1, '{EV_PIXEL, 8'hFF, 1'b0, 32'd0, 32'd0, 1'b0}},
      '{1'b0, 8'hA5,       1'b1, 1'b1, '{EV_PIXEL, 8'hA5, 1'b1, 32'd0, 32'd0, 1'b0}},
      '{1'b1, 8'h00,       1'b1, 1'b0, NoResult},
      '{1'b0, "P",         1'b0, 1'b0, NoResult},
      '{1'b0, CharHash,    1'b0, 1'b0, NoResult},
      '{1'b0, CharTab,     1'b0, 1'b0, NoResult},
      '{1'b0, "0",         1'b0, 1'b0, NoResult},
      '{1'b0, CharSpace,   1'b0, 1'b0, NoResult},
      '{1'b0, "0",         1'b0, 1'b0, NoResult},
      '{1'b0, CharSpace,   1'b0, 1'b0, NoResult},
      '{1'b0, "9",         1'b0, 1'b0, NoResult},
      '{1'b0, CharSpace,   1'b1, 1'b1, '{EV_UNSUPPORTED, 8'h00, 1'b0, 32'd0, 32'd0, 1'b0}},
      '{1'b1, 8'h5A,       1'b1, 1'b0, NoResult}
    };
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      offer(directed_rows[i].k, directed_rows[i].b, some, r);
      if (directed_rows[i].typed) begin
        if (directed_rows[i].some) pending_results = {pending_results, directed_rows[i].res};
      end else if (some) begin
        pending_results = {pending_results, r};
      end
    end

    frame_no = 0;
    while (items_sent < ItemTarget) begin
      steady = (frame_no >= 10) && (frame_no < 18);
      run_frame(frame_no);
      frame_no++;
    end
    steady = 1'b0;
    in_valid_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (error_count == 0) $display("PASS pnm_header_parser");
    else $display("FAIL pnm_header_parser");
    $finish;
  end

endmodule

/* sim.f */
hdl/pnmhp_pkg.sv
hdl/pnm_header_parser.sv
hdl/pnmhp_checker.sv
bench/pnm_header_parser_tb.sv
